/* design/sts_pkg.sv */
// shared types, widths, op codes and constant tables of the sine series block
package sts_pkg;

  // field widths
  localparam int ANGLE_W = 18;
  localparam int SINE_W  = 32;
  localparam int TERMS_W = 6;
  localparam int TOL_W   = 29;

  localparam int MAX_TERMS  = 32;
  localparam int TERM_IDX_W = $clog2(MAX_TERMS);

  localparam logic [TOL_W-1:0] TOL_RESET = 29'd268;

  // angle conversion
  localparam int AMAG_W     = 17;
  localparam int D2R_W      = 27;
  localparam int CONV_W     = 43;
  localparam int CONV_SHIFT = 12;
  localparam logic [D2R_W-1:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 18'sd92160;

  // datapath word sizes
  localparam int FRAC_W  = 28;
  localparam int XMAG_W  = 31;
  localparam int XSQ_W   = 34;
  localparam int MAG_W   = 35;
  localparam int P_W     = 41;
  localparam int RECIP_W = 39;
  localparam int DEN_W   = 13;
  localparam int SUM_W   = 40;

  // shared multiplier and accumulator
  localparam int MUL_A_W = 21;
  localparam int MUL_B_W = 39;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 80;

  // split points of the multi-cycle products
  localparam int SQ_SPLIT  = 16;
  localparam int MAG_SPLIT = 17;
  localparam int P_SPLIT   = 20;

  // datapath commands
  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] cmd_t;

  localparam cmd_t OP_NONE  = 5'd0;
  localparam cmd_t OP_LOAD  = 5'd1;
  localparam cmd_t OP_CONV  = 5'd2;
  localparam cmd_t OP_XMAG  = 5'd3;
  localparam cmd_t OP_SQ_HI = 5'd4;
  localparam cmd_t OP_SQ_LO = 5'd5;
  localparam cmd_t OP_SQ_END = 5'd6;
  localparam cmd_t OP_M_HI  = 5'd7;
  localparam cmd_t OP_M_LO  = 5'd8;
  localparam cmd_t OP_M_END = 5'd9;
  localparam cmd_t OP_D_HI  = 5'd10;
  localparam cmd_t OP_D_LO  = 5'd11;
  localparam cmd_t OP_D_END = 5'd12;
  localparam cmd_t OP_D_MUL = 5'd13;
  localparam cmd_t OP_D_FIX = 5'd14;
  localparam cmd_t OP_SUM   = 5'd15;
  localparam cmd_t OP_OUT   = 5'd16;

  typedef struct packed {
    logic stop;
    logic out_stall;
  } stat_t;

  // divisor (2k)(2k+1) of correction term k, k from 1
  localparam logic [DEN_W-1:0] DEN_TABLE [MAX_TERMS] = '{
    13'd6,    13'd20,   13'd42,   13'd72,   13'd110,  13'd156,  13'd210,  13'd272,
    13'd342,  13'd420,  13'd506,  13'd600,  13'd702,  13'd812,  13'd930,  13'd1056,
    13'd1190, 13'd1332, 13'd1482, 13'd1640, 13'd1806, 13'd1980, 13'd2162, 13'd2352,
    13'd2550, 13'd2756, 13'd2970, 13'd3192, 13'd3422, 13'd3660, 13'd3906, 13'd4160
  };

  // floor(2^41 / divisor), quotient estimate is exact or one low
  localparam logic [63:0] RECIP_NUM = 64'd1 << P_W;
  localparam logic [RECIP_W-1:0] RECIP_TABLE [MAX_TERMS] = '{
    RECIP_W'(RECIP_NUM / 6),    RECIP_W'(RECIP_NUM / 20),   RECIP_W'(RECIP_NUM / 42),
    RECIP_W'(RECIP_NUM / 72),   RECIP_W'(RECIP_NUM / 110),  RECIP_W'(RECIP_NUM / 156),
    RECIP_W'(RECIP_NUM / 210),  RECIP_W'(RECIP_NUM / 272),  RECIP_W'(RECIP_NUM / 342),
    RECIP_W'(RECIP_NUM / 420),  RECIP_W'(RECIP_NUM / 506),  RECIP_W'(RECIP_NUM / 600),
    RECIP_W'(RECIP_NUM / 702),  RECIP_W'(RECIP_NUM / 812),  RECIP_W'(RECIP_NUM / 930),
    RECIP_W'(RECIP_NUM / 1056), RECIP_W'(RECIP_NUM / 1190), RECIP_W'(RECIP_NUM / 1332),
    RECIP_W'(RECIP_NUM / 1482), RECIP_W'(RECIP_NUM / 1640), RECIP_W'(RECIP_NUM / 1806),
    RECIP_W'(RECIP_NUM / 1980), RECIP_W'(RECIP_NUM / 2162), RECIP_W'(RECIP_NUM / 2352),
    RECIP_W'(RECIP_NUM / 2550), RECIP_W'(RECIP_NUM / 2756), RECIP_W'(RECIP_NUM / 2970),
    RECIP_W'(RECIP_NUM / 3192), RECIP_W'(RECIP_NUM / 3422), RECIP_W'(RECIP_NUM / 3660),
    RECIP_W'(RECIP_NUM / 3906), RECIP_W'(RECIP_NUM / 4160)
  };

endpackage

/* design/sts_if.sv */
// request channel interfaces for angle input and sine result
interface sts_angle_if import sts_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] angle_deg;

  modport source (output valid, output angle_deg, input ready);
  modport sink (input valid, input angle_deg, output ready);
endinterface

interface sts_result_if import sts_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [SINE_W-1:0] sine_value;
  logic [TERMS_W-1:0]       terms_used;
  logic                     limit_hit;

  modport source (output valid, output sine_value, output terms_used, output limit_hit,
                  input ready);
  modport sink (input valid, input sine_value, input terms_used, input limit_hit,
                output ready);
endinterface

/* design/sts_ctrl.sv */
// sequencer for the sine series datapath
module sts_ctrl import sts_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CONV   = 4'd1;
  localparam logic [3:0] ST_XMAG   = 4'd2;
  localparam logic [3:0] ST_SQ_HI  = 4'd3;
  localparam logic [3:0] ST_SQ_LO  = 4'd4;
  localparam logic [3:0] ST_SQ_END = 4'd5;
  localparam logic [3:0] ST_M_HI   = 4'd6;
  localparam logic [3:0] ST_M_LO   = 4'd7;
  localparam logic [3:0] ST_M_END  = 4'd8;
  localparam logic [3:0] ST_D_HI   = 4'd9;
  localparam logic [3:0] ST_D_LO   = 4'd10;
  localparam logic [3:0] ST_D_END  = 4'd11;
  localparam logic [3:0] ST_D_MUL  = 4'd12;
  localparam logic [3:0] ST_D_FIX  = 4'd13;
  localparam logic [3:0] ST_SUM    = 4'd14;
  localparam logic [3:0] ST_FINISH = 4'd15;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd        = OP_LOAD;
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd        = OP_CONV;
        state_next = ST_XMAG;
      end
      ST_XMAG: begin
        cmd        = OP_XMAG;
        state_next = ST_SQ_HI;
      end
      ST_SQ_HI: begin
        cmd        = OP_SQ_HI;
        state_next = ST_SQ_LO;
      end
      ST_SQ_LO: begin
        cmd        = OP_SQ_LO;
        state_next = ST_SQ_END;
      end
      ST_SQ_END: begin
        cmd        = OP_SQ_END;
        state_next = ST_M_HI;
      end
      ST_M_HI: begin
        cmd        = OP_M_HI;
        state_next = ST_M_LO;
      end
      ST_M_LO: begin
        cmd        = OP_M_LO;
        state_next = ST_M_END;
      end
      ST_M_END: begin
        cmd        = OP_M_END;
        state_next = ST_D_HI;
      end
      ST_D_HI: begin
        cmd        = OP_D_HI;
        state_next = ST_D_LO;
      end
      ST_D_LO: begin
        cmd        = OP_D_LO;
        state_next = ST_D_END;
      end
      ST_D_END: begin
        cmd        = OP_D_END;
        state_next = ST_D_MUL;
      end
      ST_D_MUL: begin
        cmd        = OP_D_MUL;
        state_next = ST_D_FIX;
      end
      ST_D_FIX: begin
        cmd        = OP_D_FIX;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd        = OP_SUM;
        state_next = stat.stop ? ST_FINISH : ST_M_HI;
      end
      ST_FINISH: begin
        if (!stat.out_stall) begin
          cmd        = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/sts_datapath.sv */
// registers, shared multiplier and accumulator of the sine series
module sts_datapath import sts_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [TOL_W-1:0]          cfg_wr_data,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  input  cmd_t                      cmd,
  output stat_t                     stat,
  sts_result_if.source              result
);

  logic [TOL_W-1:0]        tol;
  logic [AMAG_W-1:0]       amag;
  logic                    aneg;
  logic [XMAG_W-1:0]       xmag;
  logic [XSQ_W-1:0]        xsq;
  logic [MAG_W-1:0]        tmag;
  logic                    tneg;
  logic signed [SUM_W-1:0] sum;
  logic [P_W-1:0]          preg;
  logic [MAG_W-1:0]        qreg;
  logic [TERMS_W-1:0]      count;
  logic [PROD_W-1:0]       prod;
  logic [ACC_W-1:0]        acc;

  logic                    out_valid;
  logic signed [SINE_W-1:0] out_sine;
  logic [TERMS_W-1:0]      out_terms;
  logic                    out_limit;

  logic [MUL_A_W-1:0]      mul_a;
  logic [MUL_B_W-1:0]      mul_b;
  logic [ACC_W-1:0]        acc_sum;
  logic [CONV_W-1:0]       conv_rnd;
  logic [2*XMAG_W-1:0]     sq_rnd;
  logic [P_W-1:0]          rem;
  logic [DEN_W-1:0]        den;
  logic [RECIP_W-1:0]      recip;
  logic [TERMS_W-1:0]      count_inc;
  logic signed [ANGLE_W-1:0] deg_abs;
  logic [AMAG_W-1:0]       amag_next;
  logic                    aneg_next;
  logic signed [SUM_W-1:0] xmag_ext;
  logic signed [SUM_W-1:0] tmag_ext;
  logic signed [SINE_W-1:0] sine_sat;
  logic                    tol_met;

  assign den       = DEN_TABLE[count[TERM_IDX_W-1:0]];
  assign recip     = RECIP_TABLE[count[TERM_IDX_W-1:0]];
  assign count_inc = count + TERMS_W'(1);
  assign acc_sum   = acc + ACC_W'(prod);
  assign conv_rnd  = prod[CONV_W-1:0] + (CONV_W'(1) << (CONV_SHIFT - 1));
  assign sq_rnd    = acc_sum[2*XMAG_W-1:0] + ((2*XMAG_W)'(1) << (FRAC_W - 1));
  assign rem       = preg - prod[P_W-1:0];
  assign xmag_ext  = $signed(SUM_W'(xmag));
  assign tmag_ext  = $signed(SUM_W'(tmag));
  assign tol_met   = (tmag < MAG_W'(tol));

  // input clamp to one full turn either way
  always_comb begin
    deg_abs   = angle_deg[ANGLE_W-1] ? -angle_deg : angle_deg;
    aneg_next = angle_deg[ANGLE_W-1];
    amag_next = deg_abs[AMAG_W-1:0];
    if (angle_deg > ANGLE_LIMIT || angle_deg < -ANGLE_LIMIT) begin
      amag_next = ANGLE_LIMIT[AMAG_W-1:0];
    end
  end

  // output saturation to the q3.28 range
  always_comb begin
    if (sum[SUM_W-1:SINE_W-1] == '0 || sum[SUM_W-1:SINE_W-1] == '1) begin
      sine_sat = sum[SINE_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sine_sat = {1'b1, {(SINE_W-1){1'b0}}};
    end else begin
      sine_sat = {1'b0, {(SINE_W-1){1'b1}}};
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd)
      OP_CONV: begin
        mul_a = MUL_A_W'(amag);
        mul_b = MUL_B_W'(DEG2RAD_Q32);
      end
      OP_SQ_HI: begin
        mul_a = MUL_A_W'(xmag[XMAG_W-1:SQ_SPLIT]);
        mul_b = MUL_B_W'(xmag);
      end
      OP_SQ_LO: begin
        mul_a = MUL_A_W'(xmag[SQ_SPLIT-1:0]);
        mul_b = MUL_B_W'(xmag);
      end
      OP_M_HI: begin
        mul_a = MUL_A_W'(tmag[MAG_W-1:MAG_SPLIT]);
        mul_b = MUL_B_W'(xsq);
      end
      OP_M_LO: begin
        mul_a = MUL_A_W'(tmag[MAG_SPLIT-1:0]);
        mul_b = MUL_B_W'(xsq);
      end
      OP_D_HI: begin
        mul_a = MUL_A_W'(preg[P_W-1:P_SPLIT]);
        mul_b = recip;
      end
      OP_D_LO: begin
        mul_a = MUL_A_W'(preg[P_SPLIT-1:0]);
        mul_b = recip;
      end
      OP_D_MUL: begin
        mul_a = MUL_A_W'(den);
        mul_b = MUL_B_W'(qreg);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    case (cmd)
      OP_LOAD: begin
        amag <= amag_next;
        aneg <= aneg_next;
      end
      OP_XMAG: begin
        xmag <= conv_rnd[CONV_SHIFT+XMAG_W-1:CONV_SHIFT];
      end
      OP_SQ_LO: begin
        acc <= ACC_W'(prod) << SQ_SPLIT;
      end
      OP_SQ_END: begin
        xsq  <= sq_rnd[2*XMAG_W-1:FRAC_W];
        tmag <= MAG_W'(xmag);
        tneg <= aneg;
        sum  <= aneg ? -xmag_ext : xmag_ext;
      end
      OP_M_LO: begin
        acc <= ACC_W'(prod) << MAG_SPLIT;
      end
      OP_M_END: begin
        preg <= acc_sum[FRAC_W+P_W-1:FRAC_W];
      end
      OP_D_LO: begin
        acc <= ACC_W'(prod) << P_SPLIT;
      end
      OP_D_END: begin
        qreg <= acc_sum[P_W+MAG_W-1:P_W];
      end
      OP_D_FIX: begin
        // reciprocal estimate is at most one low
        tmag <= qreg + MAG_W'(rem >= P_W'(den));
      end
      OP_SUM: begin
        tneg <= !tneg;
        sum  <= tneg ? sum + tmag_ext : sum - tmag_ext;
      end
      OP_OUT: begin
        out_sine  <= sine_sat;
        out_terms <= count;
        out_limit <= !tol_met;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tol       <= TOL_RESET;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        tol <= cfg_wr_data;
      end
      if (cmd == OP_SQ_END) begin
        count <= '0;
      end else if (cmd == OP_SUM) begin
        count <= count_inc;
      end
      if (cmd == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.stop      = tol_met || (count_inc == TERMS_W'(MAX_TERMS));
  assign stat.out_stall = out_valid && !result.ready;

  assign result.valid      = out_valid;
  assign result.sine_value = out_sine;
  assign result.terms_used = out_terms;
  assign result.limit_hit  = out_limit;

  // quotient estimate never overshoots
  a_quot_low: assert property (@(posedge clk) disable iff (rst)
    (cmd == OP_D_FIX) |-> (prod[P_W-1:0] <= preg && prod[PROD_W-1:P_W] == '0))
    else $error("quotient estimate above true quotient");

  // one correction step is enough
  a_quot_fix: assert property (@(posedge clk) disable iff (rst)
    (cmd == OP_D_FIX) |-> (rem < {{(P_W-DEN_W-1){1'b0}}, den, 1'b0}))
    else $error("quotient estimate more than one low");

  // term count stays within the limit
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= TERMS_W'(MAX_TERMS))
    else $error("term count beyond limit");

  // a result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd == OP_OUT) |-> !(out_valid && !result.ready))
    else $error("pending result overwritten");

endmodule

/* design/sine_taylor_series_tolerance.sv */
// top level of the fixed-point sine series block
//
//  channel   dir  handshake          payload
//  angle     in   valid/ready        angle_deg  s18, 8 fraction bits
//  result    out  valid/ready        sine_value s32 q3.28, terms_used u6, limit_hit u1
//  cfg       in   cfg_wr_en          cfg_wr_data u29 tolerance, 28 fraction bits
//
// one angle at a time: the result register is written after the last of the 1 to 32
// terms has been added, and the sequencer goes back to idle with that write, so a new
// angle is taken only once the result of the previous one has been written
// the per-term cost is set by the single 21x39 multiplier, used for the
// two halves of term*x^2, the two halves of the reciprocal product and the
// quotient check, plus the correction and summing steps
// reset: sequencer idle, result register empty, tolerance back to 268
// a held result does not block the next angle request; only the final write of
// the result register waits for it to be taken
// config writes are meant only while no request is in flight
//
// flow of one request
//   clamp to +-360 degrees, magnitude and sign split
//   x = |deg| * round(pi/180 * 2^32), rounded to nearest q28
//   x^2 in two partial products, rounded to q28
//   per term: p = term * x^2 / 2^28 in two partial products,
//   q = p / ((n+1)(n+2)) by table reciprocal then one correction,
//   sign flips and the sum takes the new term
//   stop once a term is below tolerance or the term limit is reached
module sine_taylor_series_tolerance import sts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [TOL_W-1:0] cfg_wr_data,
  sts_angle_if.sink        angle,
  sts_result_if.source     result
);

  // command code from the sequencer, status back from the datapath
  cmd_t  cmd;
  stat_t stat;

  sts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (angle.valid),
    .in_ready (angle.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // holds the tolerance register, the shared multiplier and the result register
  sts_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .angle_deg   (angle.angle_deg),
    .cmd         (cmd),
    .stat        (stat),
    .result      (result)
  );

endmodule

/* sim/testbench.sv */
// self-checking testbench of the fixed-point sine series block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sts_pkg::*;

  // predictor constants, kept apart from the design's own tables
  localparam longint unsigned DEG_TO_RAD_Q32 = 64'd74961321;  // round(pi/180 * 2^32)
  localparam int              MAX_DEG_Q8     = 92160;         // 360 degrees, 8 fraction bits
  localparam logic [TOL_W-1:0] TOL_AT_RESET  = 29'd268;
  localparam logic [TOL_W-1:0] TOL_MAX       = 29'h1000_0000; // 1.0 in 28 fraction bits

  localparam int HALF_PERIOD   = 6;
  localparam int SETTLE_CYCLES = 8;     // quiet time before a tolerance write
  localparam int END_CYCLES    = 320;   // longer than the slowest request
  localparam int STALL_LIMIT   = 3000;  // cycles with no handshake at all
  localparam int PHASE_ITEMS   = 152;

  typedef struct {
    logic signed [SINE_W-1:0] sine_value;
    logic [TERMS_W-1:0]       terms_used;
    logic                     limit_hit;
  } sine_result_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [TOL_W-1:0] cfg_wr_data;

  sts_angle_if  angle_ch();
  sts_result_if result_ch();

  sine_taylor_series_tolerance dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .angle       (angle_ch),
    .result      (result_ch)
  );

  // tolerance as the block should currently hold it
  logic [TOL_W-1:0] tol_setting = TOL_AT_RESET;

  // expected results, oldest first
  sine_result_t sine_expect_q[$];

  int mismatches   = 0;
  int quiet_cycles = 0;

  // runs of back-to-back traffic on each side
  int send_calm = 0;
  int take_calm = 0;

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // pause before the next request or result take: mostly random, sometimes a run of zeros
  function automatic int draw_pause(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm_left = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 11);
  endfunction

  // sine series in the block's fixed point:
  // x in q28 sign/magnitude, x^2 rounded to q28, each term truncated toward zero
  function automatic sine_result_t predict_sine(input logic signed [ANGLE_W-1:0] deg_in,
                                                input logic [TOL_W-1:0] tol);
    int              deg;
    logic            neg;
    logic            term_neg;
    longint unsigned amag;
    longint unsigned xmag;
    longint unsigned xsq;
    longint unsigned term_mag;
    longint unsigned prod;
    longint unsigned n;
    longint          acc;
    int              count;
    sine_result_t    r;
    deg = int'(deg_in);
    // clamp to one full turn either way
    if (deg > MAX_DEG_Q8) deg = MAX_DEG_Q8;
    if (deg < -MAX_DEG_Q8) deg = -MAX_DEG_Q8;
    neg = deg < 0;
    amag = neg ? longint'(-deg) : longint'(deg);
    xmag = (amag * DEG_TO_RAD_Q32 + 64'd2048) >> 12;
    xsq = (xmag * xmag + (64'd1 << 27)) >> 28;
    term_mag = xmag;
    term_neg = neg;
    acc = neg ? -longint'(xmag) : longint'(xmag);
    n = 1;
    count = 0;
    // at least one correction term, then stop on a small term or at the limit
    do begin
      prod = term_mag * (xsq >> 28) + ((term_mag * (xsq & 64'h0FFF_FFFF)) >> 28);
      term_mag = prod / ((n + 1) * (n + 2));
      term_neg = !term_neg;
      acc += term_neg ? -longint'(term_mag) : longint'(term_mag);
      n += 2;
      count++;
    end while (term_mag >= tol && count < MAX_TERMS);
    if (acc > longint'(32'sh7FFF_FFFF)) acc = longint'(32'sh7FFF_FFFF);
    if (acc < -longint'(64'h8000_0000)) acc = -longint'(64'h8000_0000);
    r.sine_value = acc[SINE_W-1:0];
    r.terms_used = count[TERMS_W-1:0];
    r.limit_hit  = term_mag >= tol;
    return r;
  endfunction

  // one angle request; returns at the edge it was taken, valid left high
  task automatic send_angle(input logic signed [ANGLE_W-1:0] deg);
    int gap;
    gap = draw_pause(send_calm);
    if (gap > 0) begin
      angle_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    angle_ch.valid     <= 1'b1;
    angle_ch.angle_deg <= deg;
    do @(posedge clk); while (!angle_ch.ready);
    sine_expect_q.push_back(predict_sine(deg, tol_setting));
  endtask

  // stop sending and wait for every outstanding result
  task automatic settle_idle();
    angle_ch.valid <= 1'b0;
    wait (sine_expect_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called at a clock edge with nothing in flight
  task automatic write_tolerance(input logic [TOL_W-1:0] tol);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= tol;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tol_setting = tol;
  endtask

  // random angle: mostly inside one turn, some near the clamp, some raw 18-bit
  function automatic logic signed [ANGLE_W-1:0] pick_angle();
    int sel;
    int v;
    sel = $urandom_range(0, 19);
    case (sel)
      0, 1: begin
        v = $urandom;
      end
      2: begin
        v = MAX_DEG_Q8 + $urandom_range(0, 600) - 300;
        if ($urandom_range(0, 1)) v = -v;
      end
      3: begin
        // whole multiples of 15 degrees
        v = 3840 * ($urandom_range(0, 48) - 24);
      end
      default: begin
        v = $urandom_range(0, 2 * MAX_DEG_Q8) - MAX_DEG_Q8;
      end
    endcase
    return v[ANGLE_W-1:0];
  endfunction

  // default tolerance straight out of reset: key angles, clamp and bit patterns
  task automatic check_reset_tolerance();
    send_angle(18'sd0);
    send_angle(18'sd1);
    send_angle(-18'sd1);
    send_angle(18'sd23040);    // 90
    send_angle(-18'sd23040);
    send_angle(18'sd46080);    // 180
    send_angle(-18'sd69120);   // -270
    send_angle(18'sd92160);    // 360, right at the clamp
    send_angle(-18'sd92160);
    send_angle(18'sd92161);    // just past the clamp
    send_angle(-18'sd92161);
    send_angle(18'sh1FFFF);    // most positive raw code
    send_angle(18'sh20000);    // most negative raw code
    send_angle(18'sh15555);
    send_angle(18'sh2AAAA);
  endtask

  // zero tolerance never stops early, then the lowest nonzero setting and 1.0
  task automatic check_tolerance_extremes();
    settle_idle();
    write_tolerance('0);
    send_angle(18'sd92160);
    send_angle(18'sd23040);
    send_angle(18'sd0);
    settle_idle();
    write_tolerance(29'd1);
    send_angle(18'sd46080);
    send_angle(-18'sd92160);
    settle_idle();
    write_tolerance(TOL_MAX);
    send_angle(18'sd92160);
    send_angle(-18'sd23040);
    send_angle(18'sd256);
  endtask

  // phases of random angles, each under its own tolerance setting
  task automatic check_random_angles();
    logic [TOL_W-1:0] tol;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: tol = 29'd1;
        1: tol = TOL_MAX;
        2: tol = 29'd1 << $urandom_range(0, 27);
        3: tol = TOL_W'($urandom_range(1, 4096));
        4: tol = TOL_W'($urandom_range(1, TOL_MAX));
        5: tol = TOL_W'($urandom_range(1, 1 << 16));
        6: tol = '0;
        7: tol = TOL_W'($urandom_range(1, TOL_MAX));
        8: tol = 29'd1 << $urandom_range(0, 28);
        default: tol = TOL_AT_RESET;
      endcase
      settle_idle();
      write_tolerance(tol);
      repeat (PHASE_ITEMS) send_angle(pick_angle());
    end
  endtask

  // result side: random stalls, each result checked against the oldest request
  initial begin
    sine_result_t want;
    result_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      int stall;
      stall = draw_pause(take_calm);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      if (sine_expect_q.size() == 0) begin
        $error("result with no request pending: sine_value %0d", result_ch.sine_value);
        mismatches++;
      end else begin
        want = sine_expect_q.pop_front();
        if (result_ch.sine_value !== want.sine_value) begin
          $error("sine_value: expected %0d, actual %0d", want.sine_value,
                 result_ch.sine_value);
          mismatches++;
        end
        if (result_ch.terms_used !== want.terms_used) begin
          $error("terms_used: expected %0d, actual %0d", want.terms_used,
                 result_ch.terms_used);
          mismatches++;
        end
        if (result_ch.limit_hit !== want.limit_hit) begin
          $error("limit_hit: expected %0d, actual %0d", want.limit_hit,
                 result_ch.limit_hit);
          mismatches++;
        end
      end
    end
  end

  // watchdog: too long without any handshake means the block hung
  always @(posedge clk) begin
    if (rst || (angle_ch.valid && angle_ch.ready) || (result_ch.valid && result_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rst                <= 1'b1;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    angle_ch.valid     <= 1'b0;
    angle_ch.angle_deg <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    check_reset_tolerance();
    check_tolerance_extremes();
    check_random_angles();

    // drain, then watch a while longer for stray results
    settle_idle();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
